// ===== rtl/vccm_pkg.sv =====
// Shared types, codes and the face corner table of the culled voxel mesher.
package vccm_pkg;

  // operation selector of an input word
  localparam logic [1:0] FUNC_WRITE = 2'd0;
  localparam logic [1:0] FUNC_READ  = 2'd1;
  localparam logic [1:0] FUNC_DIRTY = 2'd2;
  localparam logic [1:0] FUNC_MESH  = 2'd3;

  // result kinds
  localparam logic [2:0] KIND_READ   = 3'd0;
  localparam logic [2:0] KIND_VERTEX = 3'd1;
  localparam logic [2:0] KIND_EMPTY  = 3'd2;
  localparam logic [2:0] KIND_ACK    = 3'd3;
  localparam logic [2:0] KIND_REJECT = 3'd4;

  // config register indexes
  localparam logic CFG_POS_X = 1'b0;
  localparam logic CFG_POS_Z = 1'b1;

  localparam int unsigned NUM_FACES = 6;
  localparam logic [2:0]  FACE_LAST = 3'd5;
  localparam logic [2:0]  VTX_LAST  = 3'd5;

  // classified input word
  typedef struct packed {
    logic [1:0]  func;
    logic        in_range;
    logic [15:0] block_value;
  } vccm_item_t;

  // back to front control
  typedef struct packed {
    logic pop;
    logic init_done;
  } vccm_ctl_t;

  // one result word
  typedef struct packed {
    logic [2:0]  kind;
    logic [15:0] read_value;
    logic [26:0] vert_x;
    logic [8:0]  vert_y;
    logic [26:0] vert_z;
    logic        tex_u;
    logic        tex_v;
    logic [2:0]  face_dir;
    logic        last;
    logic        mesh_done;
  } vccm_res_t;

  // corner c of face f: {dx, dy, dz, u, v}
  function automatic logic [4:0] corner_of(input logic [2:0] f, input logic [1:0] c);
    logic [4:0] r;
    r = 5'b00000;
    case ({f, c})
      {3'd0, 2'd0}: r = 5'b01000;
      {3'd0, 2'd1}: r = 5'b11010;
      {3'd0, 2'd2}: r = 5'b11111;
      {3'd0, 2'd3}: r = 5'b01101;
      {3'd1, 2'd0}: r = 5'b00000;
      {3'd1, 2'd1}: r = 5'b00101;
      {3'd1, 2'd2}: r = 5'b10111;
      {3'd1, 2'd3}: r = 5'b10010;
      {3'd2, 2'd0}: r = 5'b00000;
      {3'd2, 2'd1}: r = 5'b10010;
      {3'd2, 2'd2}: r = 5'b11011;
      {3'd2, 2'd3}: r = 5'b01001;
      {3'd3, 2'd0}: r = 5'b00100;
      {3'd3, 2'd1}: r = 5'b01101;
      {3'd3, 2'd2}: r = 5'b11111;
      {3'd3, 2'd3}: r = 5'b10110;
      {3'd4, 2'd0}: r = 5'b00000;
      {3'd4, 2'd1}: r = 5'b01001;
      {3'd4, 2'd2}: r = 5'b01111;
      {3'd4, 2'd3}: r = 5'b00110;
      {3'd5, 2'd0}: r = 5'b10000;
      {3'd5, 2'd1}: r = 5'b10110;
      {3'd5, 2'd2}: r = 5'b11111;
      {3'd5, 2'd3}: r = 5'b11001;
      default:      r = 5'b00000;
    endcase
    return r;
  endfunction

  // two triangles v0 v1 v2, v0 v2 v3
  function automatic logic [1:0] quad_corner(input logic [2:0] v);
    logic [1:0] r;
    r = 2'd0;
    case (v)
      3'd0:    r = 2'd0;
      3'd1:    r = 2'd1;
      3'd2:    r = 2'd2;
      3'd3:    r = 2'd0;
      3'd4:    r = 2'd2;
      3'd5:    r = 2'd3;
      default: r = 2'd0;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/vccm_front.sv =====
// Front end: range check, address and section of input words, two-entry queue.
module vccm_front #(
  parameter int unsigned SIZE_X    = 16,
  parameter int unsigned SIZE_Z    = 16,
  parameter int unsigned HEIGHT    = 256,
  parameter int unsigned SECTION_H = 16,
  parameter int unsigned AW        = 16,
  parameter int unsigned SIW       = 4
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [1:0]             in_func_i,
  input  logic [6:0]             in_pos_x_i,
  input  logic [9:0]             in_pos_y_i,
  input  logic [6:0]             in_pos_z_i,
  input  logic [15:0]            in_block_value_i,
  input  vccm_pkg::vccm_ctl_t    ctl_i,
  output logic                   item_valid_o,
  output vccm_pkg::vccm_item_t   item_o,
  output logic [AW-1:0]          item_addr_o,
  output logic [SIW-1:0]         item_sec_o
);
  import vccm_pkg::*;

  localparam int unsigned RSH   = 20;
  localparam logic [20:0] RECIP = 21'((2 ** RSH + SECTION_H - 1) / SECTION_H);

  vccm_item_t     q_item_q [2];
  logic [AW-1:0]  q_addr_q [2];
  logic [SIW-1:0] q_sec_q  [2];
  logic           wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [1:0]     count_q, count_d;

  logic       push, in_range;
  logic [29:0] sec_prod;
  vccm_item_t cls_item;
  logic [AW-1:0] cls_addr;

  assign in_ready_o = ctl_i.init_done && (count_q != 2'd2);
  assign push       = in_valid_i && in_ready_o;

  always_comb begin
    in_range = !in_pos_x_i[6] && (int'(in_pos_x_i) < SIZE_X) &&
               !in_pos_y_i[9] && (int'(in_pos_y_i) < HEIGHT) &&
               !in_pos_z_i[6] && (int'(in_pos_z_i) < SIZE_Z);
    cls_item.func        = in_func_i;
    cls_item.in_range    = in_range;
    cls_item.block_value = in_block_value_i;
    cls_addr = AW'((int'(in_pos_y_i[8:0]) * SIZE_Z + int'(in_pos_z_i[5:0])) * SIZE_X
                   + int'(in_pos_x_i[5:0]));
    // y / SECTION_H by reciprocal, exact for y below 512
    sec_prod = 30'(in_pos_y_i[8:0]) * 30'(RECIP);
  end

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = !wr_ptr_q;
    end
    if (ctl_i.pop) begin
      rd_ptr_d = !rd_ptr_q;
    end
    count_d = count_q + 2'(push) - 2'(ctl_i.pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_item_q[wr_ptr_q] <= cls_item;
      q_addr_q[wr_ptr_q] <= cls_addr;
      q_sec_q[wr_ptr_q]  <= sec_prod[RSH +: SIW];
    end
  end

  assign item_valid_o = (count_q != 2'd0);
  assign item_o       = q_item_q[rd_ptr_q];
  assign item_addr_o  = q_addr_q[rd_ptr_q];
  assign item_sec_o   = q_sec_q[rd_ptr_q];

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q != 2'd3) else $error("queue count overrun");
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.pop |-> count_q != 2'd0) else $error("pop from empty queue");
  a_no_push_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> ctl_i.init_done) else $error("word taken during store clear");

endmodule

// ===== rtl/vccm_back.sv =====
// Back end: voxel store, dirty flags, walk sequencer and result register.
module vccm_back #(
  parameter int unsigned SIZE_X    = 16,
  parameter int unsigned SIZE_Z    = 16,
  parameter int unsigned HEIGHT    = 256,
  parameter int unsigned SECTION_H = 16,
  parameter int unsigned AW        = 16,
  parameter int unsigned SIW       = 4
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 item_valid_i,
  input  vccm_pkg::vccm_item_t item_i,
  input  logic [AW-1:0]        item_addr_i,
  input  logic [SIW-1:0]       item_sec_i,
  output vccm_pkg::vccm_ctl_t  ctl_o,
  input  logic [21:0]          cfg_pos_x_i,
  input  logic [21:0]          cfg_pos_z_i,
  output logic                 res_valid_o,
  input  logic                 res_ready_i,
  output vccm_pkg::vccm_res_t  res_o
);
  import vccm_pkg::*;

  localparam int unsigned NUM_SEC = (HEIGHT + SECTION_H - 1) / SECTION_H;
  localparam int unsigned DEPTH   = SIZE_X * SIZE_Z * HEIGHT;
  localparam int unsigned XW      = $clog2(SIZE_X);
  localparam int unsigned ZW      = $clog2(SIZE_Z);
  localparam int unsigned LYW     = (SECTION_H > 1) ? $clog2(SECTION_H) : 1;
  localparam int unsigned YW      = $clog2(NUM_SEC * SECTION_H);

  localparam logic [3:0] ST_CLEAR  = 4'd0;
  localparam logic [3:0] ST_IDLE   = 4'd1;
  localparam logic [3:0] ST_RDWAIT = 4'd2;
  localparam logic [3:0] ST_SCAN   = 4'd3;
  localparam logic [3:0] ST_STEP   = 4'd4;
  localparam logic [3:0] ST_VISIT  = 4'd5;
  localparam logic [3:0] ST_CWAIT  = 4'd6;
  localparam logic [3:0] ST_NBR    = 4'd7;
  localparam logic [3:0] ST_NWAIT  = 4'd8;
  localparam logic [3:0] ST_EMIT   = 4'd9;
  localparam logic [3:0] ST_EMPTY  = 4'd10;

  function automatic logic [AW-1:0] addr_of(input int x, input int y, input int z);
    return AW'((y * SIZE_Z + z) * SIZE_X + x);
  endfunction

  // lowest set face at or above 'from'; bit 3 flags a hit
  function automatic logic [3:0] face_from(input logic [5:0] m, input int from);
    logic [3:0] r;
    r = 4'd0;
    for (int i = NUM_FACES - 1; i >= 0; i--) begin
      if (m[i] && (i >= from)) begin
        r = {1'b1, 3'(i)};
      end
    end
    return r;
  endfunction

  // voxel store
  logic [15:0]   mem [DEPTH];
  logic          mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [15:0]   mem_wdata, mem_rdata_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    mem_rdata_q <= mem[mem_raddr];
  end

  // control state
  logic [3:0]         state_q, state_d;
  logic [AW-1:0]      clr_q, clr_d;
  logic [NUM_SEC-1:0] sec_dirty_q, sec_dirty_d;
  logic               chunk_dirty_q, chunk_dirty_d;
  logic               walk_active_q, walk_active_d;
  logic [SIW-1:0]     walk_sec_q, walk_sec_d;
  logic [XW-1:0]      cx_q, cx_d;
  logic [LYW-1:0]     cy_q, cy_d;
  logic [ZW-1:0]      cz_q, cz_d;
  logic [SIW-1:0]     scan_q, scan_d;
  logic               scan_start_q, scan_start_d;
  logic               done_q, done_d;
  logic               res_valid_q, res_valid_d;

  // payload state
  logic [XW-1:0]  vis_x_q, vis_x_d;
  logic [YW-1:0]  vis_y_q, vis_y_d;
  logic [ZW-1:0]  vis_z_q, vis_z_d;
  logic [26:0]    gx_q, gx_d, gz_q, gz_d;
  logic [2:0]     face_q, face_d, vtx_q, vtx_d;
  logic [5:0]     mask_q, mask_d;
  vccm_res_t      res_q, res_d;

  logic       emit_ok, res_load, pop;
  vccm_res_t  res_new;
  logic       nbr_in;
  logic [AW-1:0] nbr_addr;
  logic [5:0] mask_new;
  logic [3:0] nxt_face, first_face;
  logic [4:0] crn;
  logic [9:0] vy_sum;
  logic       cur_dirty;

  assign emit_ok = !res_valid_q || res_ready_i;

  always_comb begin
    nbr_in   = 1'b0;
    nbr_addr = addr_of(int'(vis_x_q), int'(vis_y_q), int'(vis_z_q));
    case (face_q)
      3'd0: begin
        nbr_in   = (int'(vis_y_q) + 1) < HEIGHT;
        nbr_addr = addr_of(int'(vis_x_q), int'(vis_y_q) + 1, int'(vis_z_q));
      end
      3'd1: begin
        nbr_in   = vis_y_q != '0;
        nbr_addr = addr_of(int'(vis_x_q), int'(vis_y_q) - 1, int'(vis_z_q));
      end
      3'd2: begin
        nbr_in   = vis_z_q != '0;
        nbr_addr = addr_of(int'(vis_x_q), int'(vis_y_q), int'(vis_z_q) - 1);
      end
      3'd3: begin
        nbr_in   = vis_z_q != ZW'(SIZE_Z - 1);
        nbr_addr = addr_of(int'(vis_x_q), int'(vis_y_q), int'(vis_z_q) + 1);
      end
      3'd4: begin
        nbr_in   = vis_x_q != '0;
        nbr_addr = addr_of(int'(vis_x_q) - 1, int'(vis_y_q), int'(vis_z_q));
      end
      3'd5: begin
        nbr_in   = vis_x_q != XW'(SIZE_X - 1);
        nbr_addr = addr_of(int'(vis_x_q) + 1, int'(vis_y_q), int'(vis_z_q));
      end
      default: begin
        nbr_in   = 1'b0;
      end
    endcase
  end

  always_comb begin
    nxt_face = face_from(mask_q, int'(face_q) + 1);
    crn      = corner_of(face_q, quad_corner(vtx_q));
    vy_sum   = 10'(vis_y_q) + 10'(crn[3]);
    cur_dirty = sec_dirty_q[scan_q];
  end

  always_comb begin
    state_d       = state_q;
    clr_d         = clr_q;
    sec_dirty_d   = sec_dirty_q;
    chunk_dirty_d = chunk_dirty_q;
    walk_active_d = walk_active_q;
    walk_sec_d    = walk_sec_q;
    cx_d          = cx_q;
    cy_d          = cy_q;
    cz_d          = cz_q;
    scan_d        = scan_q;
    scan_start_d  = scan_start_q;
    done_d        = done_q;
    vis_x_d       = vis_x_q;
    vis_y_d       = vis_y_q;
    vis_z_d       = vis_z_q;
    gx_d          = gx_q;
    gz_d          = gz_q;
    face_d        = face_q;
    vtx_d         = vtx_q;
    mask_d        = mask_q;
    mask_new      = mask_q;
    first_face    = 4'd0;
    mem_we        = 1'b0;
    mem_waddr     = item_addr_i;
    mem_wdata     = item_i.block_value;
    mem_raddr     = item_addr_i;
    res_load      = 1'b0;
    res_new       = '0;
    pop           = 1'b0;

    case (state_q)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        mem_wdata = '0;
        clr_d     = clr_q + 1'b1;
        if (clr_q == AW'(DEPTH - 1)) begin
          state_d = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (item_valid_i) begin
          case (item_i.func)
            FUNC_WRITE: begin
              if (emit_ok) begin
                res_load     = 1'b1;
                res_new.last = 1'b1;
                pop          = 1'b1;
                if (walk_active_q) begin
                  res_new.kind = KIND_REJECT;
                end else begin
                  res_new.kind = KIND_ACK;
                  if (item_i.in_range) begin
                    mem_we                  = 1'b1;
                    sec_dirty_d[item_sec_i] = 1'b1;
                    chunk_dirty_d           = 1'b1;
                  end
                end
              end
            end
            FUNC_READ: begin
              state_d = ST_RDWAIT;
            end
            FUNC_DIRTY: begin
              if (emit_ok) begin
                res_load     = 1'b1;
                res_new.last = 1'b1;
                pop          = 1'b1;
                if (walk_active_q) begin
                  res_new.kind = KIND_REJECT;
                end else begin
                  res_new.kind  = KIND_ACK;
                  sec_dirty_d   = '1;
                  chunk_dirty_d = 1'b1;
                end
              end
            end
            FUNC_MESH: begin
              if (walk_active_q) begin
                state_d = ST_STEP;
              end else if (!chunk_dirty_q) begin
                done_d  = 1'b1;
                state_d = ST_EMPTY;
              end else begin
                scan_d       = '0;
                scan_start_d = 1'b1;
                state_d      = ST_SCAN;
              end
            end
            default: begin
              state_d = ST_IDLE;
            end
          endcase
        end
      end

      ST_RDWAIT: begin
        if (emit_ok) begin
          res_load           = 1'b1;
          res_new.kind       = KIND_READ;
          res_new.read_value = item_i.in_range ? mem_rdata_q : 16'd0;
          res_new.last       = 1'b1;
          pop                = 1'b1;
          state_d            = ST_IDLE;
        end
      end

      // one section flag per cycle
      ST_SCAN: begin
        if (cur_dirty) begin
          walk_sec_d = scan_q;
          if (scan_start_q) begin
            walk_active_d = 1'b1;
            cx_d          = '0;
            cy_d          = '0;
            cz_d          = '0;
            state_d       = ST_STEP;
          end else begin
            state_d = ST_VISIT;
          end
        end else if (scan_q == SIW'(NUM_SEC - 1)) begin
          chunk_dirty_d = 1'b0;
          done_d        = 1'b1;
          if (scan_start_q) begin
            state_d = ST_EMPTY;
          end else begin
            walk_active_d = 1'b0;
            walk_sec_d    = '0;
            state_d       = ST_VISIT;
          end
        end else begin
          scan_d = scan_q + 1'b1;
        end
      end

      // latch the voxel, advance the cursor
      ST_STEP: begin
        vis_x_d = cx_q;
        vis_z_d = cz_q;
        vis_y_d = YW'(int'(walk_sec_q) * SECTION_H + int'(cy_q));
        done_d  = 1'b0;
        state_d = ST_VISIT;
        if (cz_q == ZW'(SIZE_Z - 1)) begin
          cz_d = '0;
          if (cy_q == LYW'(SECTION_H - 1)) begin
            cy_d = '0;
            if (cx_q == XW'(SIZE_X - 1)) begin
              cx_d                    = '0;
              sec_dirty_d[walk_sec_q] = 1'b0;
              if (walk_sec_q == SIW'(NUM_SEC - 1)) begin
                walk_active_d = 1'b0;
                walk_sec_d    = '0;
                chunk_dirty_d = 1'b0;
                done_d        = 1'b1;
              end else begin
                scan_d       = walk_sec_q + 1'b1;
                scan_start_d = 1'b0;
                state_d      = ST_SCAN;
              end
            end else begin
              cx_d = cx_q + 1'b1;
            end
          end else begin
            cy_d = cy_q + 1'b1;
          end
        end else begin
          cz_d = cz_q + 1'b1;
        end
      end

      ST_VISIT: begin
        gx_d = 27'(28'($signed(cfg_pos_x_i)) * 28'(SIZE_X)) + 27'(vis_x_q);
        gz_d = 27'(28'($signed(cfg_pos_z_i)) * 28'(SIZE_Z)) + 27'(vis_z_q);
        mem_raddr = addr_of(int'(vis_x_q), int'(vis_y_q), int'(vis_z_q));
        if (int'(vis_y_q) >= HEIGHT) begin
          state_d = ST_EMPTY;
        end else begin
          state_d = ST_CWAIT;
        end
      end

      ST_CWAIT: begin
        if (mem_rdata_q == 16'd0) begin
          state_d = ST_EMPTY;
        end else begin
          face_d  = '0;
          mask_d  = '0;
          state_d = ST_NBR;
        end
      end

      ST_NBR, ST_NWAIT: begin
        mem_raddr = nbr_addr;
        if ((state_q == ST_NBR) && nbr_in) begin
          state_d = ST_NWAIT;
        end else begin
          mask_new[face_q] = (state_q == ST_NBR) ? 1'b1 : (mem_rdata_q == 16'd0);
          mask_d           = mask_new;
          first_face       = face_from(mask_new, 0);
          if (face_q == FACE_LAST) begin
            if (first_face[3]) begin
              face_d  = first_face[2:0];
              vtx_d   = '0;
              state_d = ST_EMIT;
            end else begin
              state_d = ST_EMPTY;
            end
          end else begin
            face_d  = face_q + 1'b1;
            state_d = ST_NBR;
          end
        end
      end

      ST_EMIT: begin
        if (emit_ok) begin
          res_load          = 1'b1;
          res_new.kind      = KIND_VERTEX;
          res_new.vert_x    = gx_q + 27'(crn[4]);
          res_new.vert_y    = vy_sum[8:0];
          res_new.vert_z    = gz_q + 27'(crn[2]);
          res_new.tex_u     = crn[1];
          res_new.tex_v     = crn[0];
          res_new.face_dir  = face_q;
          res_new.mesh_done = done_q;
          res_new.last      = (vtx_q == VTX_LAST) && !nxt_face[3];
          if (vtx_q == VTX_LAST) begin
            vtx_d = '0;
            if (nxt_face[3]) begin
              face_d = nxt_face[2:0];
            end else begin
              pop     = 1'b1;
              state_d = ST_IDLE;
            end
          end else begin
            vtx_d = vtx_q + 1'b1;
          end
        end
      end

      ST_EMPTY: begin
        if (emit_ok) begin
          res_load          = 1'b1;
          res_new.kind      = KIND_EMPTY;
          res_new.last      = 1'b1;
          res_new.mesh_done = done_q;
          pop               = 1'b1;
          state_d           = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase

    res_valid_d = res_load ? 1'b1 : (res_ready_i ? 1'b0 : res_valid_q);
    res_d       = res_load ? res_new : res_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_CLEAR;
      clr_q         <= '0;
      sec_dirty_q   <= '1;
      chunk_dirty_q <= 1'b1;
      walk_active_q <= 1'b0;
      walk_sec_q    <= '0;
      cx_q          <= '0;
      cy_q          <= '0;
      cz_q          <= '0;
      scan_q        <= '0;
      scan_start_q  <= 1'b0;
      done_q        <= 1'b0;
      res_valid_q   <= 1'b0;
    end else begin
      state_q       <= state_d;
      clr_q         <= clr_d;
      sec_dirty_q   <= sec_dirty_d;
      chunk_dirty_q <= chunk_dirty_d;
      walk_active_q <= walk_active_d;
      walk_sec_q    <= walk_sec_d;
      cx_q          <= cx_d;
      cy_q          <= cy_d;
      cz_q          <= cz_d;
      scan_q        <= scan_d;
      scan_start_q  <= scan_start_d;
      done_q        <= done_d;
      res_valid_q   <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    vis_x_q <= vis_x_d;
    vis_y_q <= vis_y_d;
    vis_z_q <= vis_z_d;
    gx_q    <= gx_d;
    gz_q    <= gz_d;
    face_q  <= face_d;
    vtx_q   <= vtx_d;
    mask_q  <= mask_d;
    res_q   <= res_d;
  end

  assign ctl_o.pop       = pop;
  assign ctl_o.init_done = (state_q != ST_CLEAR);
  assign res_valid_o     = res_valid_q;
  assign res_o           = res_q;

  a_walk_dirty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    walk_active_q |-> chunk_dirty_q) else $error("walk running on clean chunk");
  a_pop_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> res_load && res_new.last) else $error("word retired without last result");
  a_load_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_load |-> emit_ok) else $error("result register overwritten");
  a_emit_face: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_EMIT |-> mask_q[face_q]) else $error("emitting a hidden face");

endmodule

// ===== rtl/voxel_chunk_face_culling_mesher_unit.sv =====
// Top level of the culled voxel chunk mesher: ports, config registers, front and back.
//
//  channel   | direction | handshake              | payload
//  ----------+-----------+------------------------+-----------------------------------
//  s_axis    | in        | s_axis_tvalid/tready   | tuser func, tdata pos and block id
//  m_axis    | out       | m_axis_tvalid/tready   | tuser kind+done, tdata vertex, tlast
//  cfg       | in        | cfg_valid_i/cfg_ready_o| cfg_index_i, cfg_data_i
//
// Write and mark-dirty are answered straight from the idle state of the back end; a read
// waits on one store read. Mesh step: the walk latches the voxel, reads it and then its six
// neighbours one after another (one store read port), then emits its vertex words (6 per
// visible face, up to 36); the result register is the bound on a solid voxel. Finding the
// next dirty section scans one flag per cycle at a section boundary.
// Reset: the voxel store is swept to air, one entry per cycle, over all SIZE_X*SIZE_Z*HEIGHT
// entries (65536 with the defaults); s_axis_tready stays low until it finishes,
// config writes are taken throughout.
// Stalls: a two-word queue sits between front and back, so input is taken while
// the back end waits on m_axis_tready.
module voxel_chunk_face_culling_mesher_unit #(
  parameter int unsigned SIZE_X    = 16,
  parameter int unsigned SIZE_Z    = 16,
  parameter int unsigned HEIGHT    = 256,
  parameter int unsigned SECTION_H = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // pos_x[6:0], pos_y[16:7], pos_z[23:17], block_value[39:24]
  input  logic [1:0]  s_axis_tuser,   // func[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [87:0] m_axis_tdata,   // read_value[15:0], vert_x[42:16], vert_y[51:43],
                                      // vert_z[78:52], tex_u[79], tex_v[80], face_dir[83:81]
  output logic [3:0]  m_axis_tuser,   // kind[2:0], mesh_done[3]
  output logic        m_axis_tlast,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [21:0] cfg_data_i
);
  import vccm_pkg::*;

  localparam int unsigned NUM_SEC = (HEIGHT + SECTION_H - 1) / SECTION_H;
  localparam int unsigned AW      = $clog2(SIZE_X * SIZE_Z * HEIGHT);
  localparam int unsigned SIW     = (NUM_SEC > 1) ? $clog2(NUM_SEC) : 1;

  logic [21:0] pos_x_q, pos_x_d, pos_z_q, pos_z_d;

  vccm_ctl_t      ctl;
  logic           item_valid;
  vccm_item_t     item;
  logic [AW-1:0]  item_addr;
  logic [SIW-1:0] item_sec;
  vccm_res_t      res;

  // config words are always taken; writes must come only while idle, which the block does not enforce
  assign cfg_ready_o = 1'b1;

  always_comb begin
    pos_x_d = pos_x_q;
    pos_z_d = pos_z_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_POS_X: pos_x_d = cfg_data_i;
        CFG_POS_Z: pos_z_d = cfg_data_i;
        default:   pos_x_d = pos_x_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_x_q <= '0;
      pos_z_q <= '0;
    end else begin
      pos_x_q <= pos_x_d;
      pos_z_q <= pos_z_d;
    end
  end

  vccm_front #(
    .SIZE_X   (SIZE_X),
    .SIZE_Z   (SIZE_Z),
    .HEIGHT   (HEIGHT),
    .SECTION_H(SECTION_H),
    .AW       (AW),
    .SIW      (SIW)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (s_axis_tvalid),
    .in_ready_o      (s_axis_tready),
    .in_func_i       (s_axis_tuser),
    .in_pos_x_i      (s_axis_tdata[6:0]),
    .in_pos_y_i      (s_axis_tdata[16:7]),
    .in_pos_z_i      (s_axis_tdata[23:17]),
    .in_block_value_i(s_axis_tdata[39:24]),
    .ctl_i           (ctl),
    .item_valid_o    (item_valid),
    .item_o          (item),
    .item_addr_o     (item_addr),
    .item_sec_o      (item_sec)
  );

  vccm_back #(
    .SIZE_X   (SIZE_X),
    .SIZE_Z   (SIZE_Z),
    .HEIGHT   (HEIGHT),
    .SECTION_H(SECTION_H),
    .AW       (AW),
    .SIW      (SIW)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_valid_i(item_valid),
    .item_i      (item),
    .item_addr_i (item_addr),
    .item_sec_i  (item_sec),
    .ctl_o       (ctl),
    .cfg_pos_x_i (pos_x_q),
    .cfg_pos_z_i (pos_z_q),
    .res_valid_o (m_axis_tvalid),
    .res_ready_i (m_axis_tready),
    .res_o       (res)
  );

  assign m_axis_tdata = {4'd0, res.face_dir, res.tex_v, res.tex_u, res.vert_z,
                         res.vert_y, res.vert_x, res.read_value};
  assign m_axis_tuser = {res.mesh_done, res.kind};
  assign m_axis_tlast = res.last;

endmodule

// ===== sim/tb_vccm_checker.sv =====
// Checker of the voxel mesher: watches the channels, predicts result words and compares them.
`timescale 1ns / 100ps

module tb_vccm_checker
  import vccm_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  input  logic        s_tready_i,
  input  logic [39:0] s_tdata_i,
  input  logic [1:0]  s_tuser_i,
  input  logic        m_tvalid_i,
  input  logic        m_tready_i,
  input  logic [87:0] m_tdata_i,
  input  logic [3:0]  m_tuser_i,
  input  logic        m_tlast_i,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic        cfg_index_i,
  input  logic [21:0] cfg_data_i,
  input  logic        drain_chk_i,
  output int          fail_cnt_o
);

  localparam int SX = 16;
  localparam int SZ = 16;
  localparam int HEIGHT = 256;
  localparam int SEC_H = 16;
  localparam int N_SEC = 16;
  localparam int SEC_VOX = SX * SZ * SEC_H;

  // neighbour offsets per face
  localparam int NB_X [6] = '{0, 0, 0, 0, -1, 1};
  localparam int NB_Y [6] = '{1, -1, 0, 0, 0, 0};
  localparam int NB_Z [6] = '{0, 0, -1, 1, 0, 0};
  // corner {dx, dy, dz, u, v}, four per face
  localparam bit [4:0] FACE_CORNER [24] = '{
    5'b01000, 5'b11010, 5'b11111, 5'b01101,
    5'b00000, 5'b00101, 5'b10111, 5'b10010,
    5'b00000, 5'b10010, 5'b11011, 5'b01001,
    5'b00100, 5'b01101, 5'b11111, 5'b10110,
    5'b00000, 5'b01001, 5'b01111, 5'b00110,
    5'b10000, 5'b10110, 5'b11111, 5'b11001};
  localparam int TRI_CORNER [6] = '{0, 1, 2, 0, 2, 3};

  logic [15:0]        voxels [SX*SZ*HEIGHT];
  bit                 sec_dirty [N_SEC];
  bit                 chunk_dirty;
  bit                 walk_on;
  int                 walk_sec;
  int                 walk_pos;
  logic signed [21:0] chunk_x;
  logic signed [21:0] chunk_z;
  vccm_res_t          pending_q [$];
  int                 fails;

  assign fail_cnt_o = fails;

  initial begin
    fails = 0;
    foreach (voxels[i]) voxels[i] = '0;
    foreach (sec_dirty[i]) sec_dirty[i] = 1'b1;
    chunk_dirty = 1'b1;
    walk_on = 1'b0;
    walk_sec = 0;
    walk_pos = 0;
    chunk_x = '0;
    chunk_z = '0;
  end

  function automatic bit in_chunk(int x, int y, int z);
    return x >= 0 && x < SX && y >= 0 && y < HEIGHT && z >= 0 && z < SZ;
  endfunction

  function automatic logic [15:0] block_at(int x, int y, int z);
    if (!in_chunk(x, y, z)) return '0;
    return voxels[(y * SZ + z) * SX + x];
  endfunction

  function automatic int first_dirty(int from);
    for (int s = from; s < N_SEC; s++) if (sec_dirty[s]) return s;
    return N_SEC;
  endfunction

  task automatic report(string msg);
    fails++;
    $display("%0t mismatch: %s", $realtime, msg);
  endtask

  task automatic push_single(logic [2:0] kind, logic [15:0] value, bit done);
    vccm_res_t r;
    r = '0;
    r.kind = kind;
    r.read_value = value;
    r.last = 1'b1;
    r.mesh_done = done;
    pending_q = {pending_q, r};
  endtask

  task automatic predict_mesh();
    vccm_res_t r;
    vccm_res_t grp [$];
    int        s, lx, ly, lz, y, gx, gz;
    bit        fin;
    bit [4:0]  cr;
    fin = 1'b0;
    if (!walk_on) begin
      s = chunk_dirty ? first_dirty(0) : N_SEC;
      if (s >= N_SEC) begin
        chunk_dirty = 1'b0;
        push_single(KIND_EMPTY, '0, 1'b1);
        return;
      end
      walk_on = 1'b1;
      walk_sec = s;
      walk_pos = 0;
    end
    lz = walk_pos % SZ;
    ly = (walk_pos / SZ) % SEC_H;
    lx = walk_pos / (SZ * SEC_H);
    y  = walk_sec * SEC_H + ly;
    if (y < HEIGHT && block_at(lx, y, lz) != 0) begin
      gx = int'(chunk_x) * SX + lx;
      gz = int'(chunk_z) * SZ + lz;
      for (int f = 0; f < 6; f++) begin
        if (in_chunk(lx + NB_X[f], y + NB_Y[f], lz + NB_Z[f]) &&
            block_at(lx + NB_X[f], y + NB_Y[f], lz + NB_Z[f]) != 0) continue;
        for (int v = 0; v < 6; v++) begin
          cr = FACE_CORNER[f * 4 + TRI_CORNER[v]];
          r = '0;
          r.kind     = KIND_VERTEX;
          r.vert_x   = 27'(gx + int'(cr[4]));
          r.vert_y   = 9'(y + int'(cr[3]));
          r.vert_z   = 27'(gz + int'(cr[2]));
          r.tex_u    = cr[1];
          r.tex_v    = cr[0];
          r.face_dir = 3'(f);
          grp = {grp, r};
        end
      end
    end
    walk_pos++;
    if (walk_pos >= SEC_VOX) begin
      sec_dirty[walk_sec] = 1'b0;
      s = first_dirty(walk_sec + 1);
      walk_pos = 0;
      if (s >= N_SEC) begin
        walk_on = 1'b0;
        walk_sec = 0;
        chunk_dirty = 1'b0;
        fin = 1'b1;
      end else begin
        walk_sec = s;
      end
    end
    if (grp.size() == 0) begin
      r = '0;
      r.kind = KIND_EMPTY;
      grp = {grp, r};
    end
    foreach (grp[k]) begin
      grp[k].mesh_done = fin;
      grp[k].last = (k == grp.size() - 1);
      pending_q = {pending_q, grp[k]};
    end
  endtask

  task automatic predict_word(logic [1:0] func, logic [39:0] d);
    int x, y, z;
    x = $signed(d[6:0]);
    y = $signed(d[16:7]);
    z = $signed(d[23:17]);
    case (func)
      FUNC_WRITE: begin
        if (walk_on) begin
          push_single(KIND_REJECT, '0, 1'b0);
        end else begin
          if (in_chunk(x, y, z)) begin
            voxels[(y * SZ + z) * SX + x] = d[39:24];
            sec_dirty[y / SEC_H] = 1'b1;
            chunk_dirty = 1'b1;
          end
          push_single(KIND_ACK, '0, 1'b0);
        end
      end
      FUNC_READ: push_single(KIND_READ, block_at(x, y, z), 1'b0);
      FUNC_DIRTY: begin
        if (walk_on) begin
          push_single(KIND_REJECT, '0, 1'b0);
        end else begin
          foreach (sec_dirty[i]) sec_dirty[i] = 1'b1;
          chunk_dirty = 1'b1;
          push_single(KIND_ACK, '0, 1'b0);
        end
      end
      default: predict_mesh();
    endcase
  endtask

  task automatic compare_word();
    vccm_res_t got, want;
    string     bad;
    got.kind       = m_tuser_i[2:0];
    got.mesh_done  = m_tuser_i[3];
    got.last       = m_tlast_i;
    got.read_value = m_tdata_i[15:0];
    got.vert_x     = m_tdata_i[42:16];
    got.vert_y     = m_tdata_i[51:43];
    got.vert_z     = m_tdata_i[78:52];
    got.tex_u      = m_tdata_i[79];
    got.tex_v      = m_tdata_i[80];
    got.face_dir   = m_tdata_i[83:81];
    if (pending_q.size() == 0) begin
      report($sformatf("unexpected result word kind %0d", got.kind));
      return;
    end
    want = pending_q.pop_front();
    bad = "";
    if (got.kind != want.kind) bad = {bad, " kind"};
    if (got.read_value != want.read_value) bad = {bad, " read_value"};
    if (got.vert_x != want.vert_x) bad = {bad, " vert_x"};
    if (got.vert_y != want.vert_y) bad = {bad, " vert_y"};
    if (got.vert_z != want.vert_z) bad = {bad, " vert_z"};
    if (got.tex_u != want.tex_u) bad = {bad, " tex_u"};
    if (got.tex_v != want.tex_v) bad = {bad, " tex_v"};
    if (got.face_dir != want.face_dir) bad = {bad, " face_dir"};
    if (got.last != want.last) bad = {bad, " last"};
    if (got.mesh_done != want.mesh_done) bad = {bad, " mesh_done"};
    if (bad != "")
      report($sformatf("field(s)%s: got %h want %h", bad, got, want));
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == CFG_POS_X) chunk_x = cfg_data_i;
        else chunk_z = cfg_data_i;
      end
      if (m_tvalid_i && m_tready_i) compare_word();
      if (s_tvalid_i && s_tready_i) predict_word(s_tuser_i, s_tdata_i);
      if (drain_chk_i && pending_q.size() != 0)
        report($sformatf("%0d result words never arrived", pending_q.size()));
    end
  end

endmodule

// ===== sim/tb_voxel_chunk_face_culling_mesher_unit.sv =====
// Testbench top of the voxel mesher: clock, reset, stimulus, stall patterns and verdict.
`timescale 1ns / 100ps

module tb_voxel_chunk_face_culling_mesher_unit;
  import vccm_pkg::*;

  localparam int IDLE_LIMIT = 200000;  // covers the store sweep after reset
  localparam logic [21:0] POS_MAX = 22'h1FFFFF;
  localparam logic [21:0] POS_MIN = 22'h200000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;  // pos_x, pos_y, pos_z, block_value from bit 0 up
  logic [1:0]  s_axis_tuser = '0;  // func
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [87:0] m_axis_tdata;       // read_value, vert_x, vert_y, vert_z, tex_u, tex_v, face_dir
  logic [3:0]  m_axis_tuser;       // kind, mesh_done
  logic        m_axis_tlast;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic        cfg_index_i = 1'b0;
  logic [21:0] cfg_data_i = '0;
  logic        drain_chk = 1'b0;
  int          fail_cnt;

  // traffic counters
  int words_in = 0, words_out = 0, lasts_out = 0, verts_out = 0;
  int burst_left = 0;
  int gap_max = 6;
  int stall_cyc = 0;
  int quiet_cyc = 0;

  voxel_chunk_face_culling_mesher_unit uut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser, .m_axis_tlast,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  tb_vccm_checker chk (
    .clk_i, .rst_ni,
    .s_tvalid_i(s_axis_tvalid), .s_tready_i(s_axis_tready),
    .s_tdata_i(s_axis_tdata), .s_tuser_i(s_axis_tuser),
    .m_tvalid_i(m_axis_tvalid), .m_tready_i(m_axis_tready),
    .m_tdata_i(m_axis_tdata), .m_tuser_i(m_axis_tuser), .m_tlast_i(m_axis_tlast),
    .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_index_i, .cfg_data_i,
    .drain_chk_i(drain_chk), .fail_cnt_o(fail_cnt)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // count words both ways
  always @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) words_in++;
    if (m_axis_tvalid && m_axis_tready) begin
      words_out++;
      if (m_axis_tlast) lasts_out++;
      if (m_axis_tuser[2:0] == KIND_VERTEX) verts_out++;
    end
  end

  // watchdog: cycles with no handshake on any channel
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cyc = 0;
    end else begin
      quiet_cyc++;
      if (quiet_cyc >= IDLE_LIMIT) begin
        $display("timeout after %0d idle cycles", quiet_cyc);
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // receiver stall: bits 9:8 of stall_cyc pick the pattern
  always @(negedge clk_i) begin
    stall_cyc++;
    case (stall_cyc[9:8])
      2'd0: m_axis_tready <= 1'b1;
      2'd1: m_axis_tready <= ($urandom_range(0, 3) != 0);
      2'd2: m_axis_tready <= ($urandom_range(0, 3) == 0);
      default: m_axis_tready <= (stall_cyc[2:0] != 3'd0);
    endcase
  end

  // one input word; bursts of random length with random gaps between them
  task automatic send_word(logic [1:0] func, logic [6:0] px, logic [9:0] py,
                           logic [6:0] pz, logic [15:0] value);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = $urandom_range(0, gap_max);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= func;
    s_axis_tdata  <= {value, pz, py, px};
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  task automatic write_reg(logic index, logic [21:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // every word closes with one tlast, so equal counts mean the block is idle
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    while (lasts_out != words_in) @(posedge clk_i);
    repeat (40) @(negedge clk_i);
  endtask

  function automatic logic [6:0] pick_xz();
    if ($urandom_range(0, 3) == 0) return $urandom_range(0, 1) ? 7'd15 : 7'd0;
    return 7'($urandom_range(0, 15));
  endfunction

  // writes, reads in x 0-1, y 0-17, where the walk starts, plus random writes and reads
  task automatic fill_blocks(int n);
    int r;
    logic [6:0] px;
    logic [9:0] py;
    repeat (n) begin
      r  = $urandom_range(0, 99);
      px = 7'($urandom_range(0, 1));
      py = 10'($urandom_range(0, 17));
      if (r < 70)
        send_word(FUNC_WRITE, px, py, pick_xz(),
                  ($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom_range(1, 65535)));
      else if (r < 85)
        send_word(FUNC_READ, px, py, pick_xz(), 16'($urandom));
      else
        send_word(2'($urandom_range(0, 1)), 7'($urandom), 10'($urandom), 7'($urandom),
                  16'($urandom));
    end
  endtask

  // mesh steps with writes and marks mixed in, which come back rejected, and reads
  task automatic mesh_steps(int n);
    int r;
    gap_max = 2;
    repeat (n) begin
      r = $urandom_range(0, 99);
      if (r < 8)
        send_word(2'($urandom_range(0, 2)), 7'($urandom), 10'($urandom), 7'($urandom),
                  16'($urandom));
      else if (r < 10)
        send_word(FUNC_READ, pick_xz(), 10'($urandom_range(0, 255)), pick_xz(),
                  16'($urandom));
      else
        send_word(FUNC_MESH, 7'($urandom), 10'($urandom), 7'($urandom), 16'($urandom));
    end
    gap_max = 6;
  endtask

  // new chunk position between steps, then more of the walk
  task automatic run_phase(logic [21:0] cx, logic [21:0] cz, int n);
    wait_idle();
    write_reg(CFG_POS_X, cx);
    write_reg(CFG_POS_Z, cz);
    mesh_steps(n);
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    // register extremes for the first steps, written during the store sweep
    write_reg(CFG_POS_X, POS_MAX);
    write_reg(CFG_POS_Z, POS_MIN);

    // directed: corners, out-of-range on every axis, air, reads, mark
    send_word(FUNC_WRITE, 7'd0, 10'd0, 7'd0, 16'hFFFF);
    send_word(FUNC_WRITE, 7'd15, 10'd255, 7'd15, 16'h8001);
    send_word(FUNC_WRITE, 7'h40, 10'h200, 7'h40, 16'h1234);
    send_word(FUNC_WRITE, 7'h3F, 10'h1FF, 7'h3F, 16'hEDCB);
    send_word(FUNC_WRITE, 7'd16, 10'd0, 7'd0, 16'd5);
    send_word(FUNC_WRITE, 7'd0, 10'd256, 7'd0, 16'd5);
    send_word(FUNC_WRITE, 7'd0, 10'd0, 7'd16, 16'd5);
    send_word(FUNC_WRITE, 7'd1, 10'd0, 7'd0, 16'd0);
    send_word(FUNC_WRITE, 7'd0, 10'd1, 7'd0, 16'd7);
    send_word(FUNC_READ, 7'd0, 10'd0, 7'd0, 16'd0);
    send_word(FUNC_READ, 7'd15, 10'd255, 7'd15, 16'hFFFF);
    send_word(FUNC_READ, 7'h7F, 10'd0, 7'd0, 16'd0);
    send_word(FUNC_READ, 7'h3F, 10'h1FF, 7'h3F, 16'd0);
    send_word(FUNC_READ, 7'd0, 10'h200, 7'd0, 16'd0);
    send_word(FUNC_DIRTY, 7'd0, 10'd0, 7'd0, 16'd0);
    fill_blocks(70);
    // walk start, then a write and a mark that must be rejected, and a read
    send_word(FUNC_MESH, 7'd0, 10'd0, 7'd0, 16'd0);
    send_word(FUNC_WRITE, 7'd2, 10'd2, 7'd2, 16'd1);
    send_word(FUNC_DIRTY, 7'd0, 10'd0, 7'd0, 16'd0);
    send_word(FUNC_READ, 7'd0, 10'd1, 7'd0, 16'd0);
    mesh_steps(130);

    run_phase(POS_MIN, POS_MAX, 110);
    run_phase(22'($urandom), 22'($urandom), 100);

    wait_idle();
    repeat (60) @(negedge clk_i);
    drain_chk <= 1'b1;
    @(negedge clk_i);
    drain_chk <= 1'b0;
    @(negedge clk_i);
    $display("covered %0d input words and %0d result words, %0d of them vertices",
             words_in, words_out, verts_out);
    $display("edge and out-of-range accesses, then walk steps over the lowest section");
    if (fail_cnt == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d mismatches", fail_cnt);
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/vccm_pkg.sv
rtl/vccm_front.sv
rtl/vccm_back.sv
rtl/voxel_chunk_face_culling_mesher_unit.sv
sim/tb_vccm_checker.sv
sim/tb_voxel_chunk_face_culling_mesher_unit.sv
